FILE: rtl/cruijff_function_eval_core_macros.svh
// assertion macros for the cruijff function evaluator
`ifndef CRUIJFF_FUNCTION_EVAL_CORE_MACROS_SVH
`define CRUIJFF_FUNCTION_EVAL_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cfe_pkg.sv
// shared constants and types of the cruijff function evaluator
`default_nettype none
package cfe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OUT_BITS  = 16;

  localparam int WORD_W  = 32;
  localparam int D2_W    = 2 * WORD_W;
  localparam int PROD_W  = 3 * WORD_W;
  localparam int DEN_W   = PROD_W - FRAC_BITS + 1;
  localparam int NUM_W   = D2_W + FRAC_BITS;
  // integer part of the exponent, saturation at 2**N_W
  localparam int N_W     = 5;
  localparam int Q_W     = FRAC_BITS + N_W;
  localparam int CMP_W   = DEN_W + Q_W;
  localparam int NPOW    = (1 << N_W) - 1;
  localparam int FX_W    = 32;
  localparam int ACC_W   = FX_W + 1;
  localparam int NTERMS  = 16;
  localparam int RCP_W   = 32;
  localparam int RCP_SHIFT = 33;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] SIGN_BIT    = WORD_W'(1) << (WORD_W - 1);
  localparam logic [WORD_W-1:0] WIDTH_RESET = WORD_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]  FX_ONE      = ACC_W'(1) << FX_W;
  localparam logic [OUT_BITS:0] DENSITY_ONE = (OUT_BITS + 1)'(1) << OUT_BITS;

  // exp(-1) in Q0.32, the rounded square of the series value at one half
  localparam logic [FX_W-1:0] E1 = 32'd1580030168;

  // floor(2**33 / k); powers of two use a shift and keep 0 here
  localparam logic [RCP_W-1:0] RCP_TAB [NTERMS+1] = '{
    32'd0,          32'd0,          32'd0,          32'd2863311530,
    32'd0,          32'd1717986918, 32'd1431655765, 32'd1227133513,
    32'd0,          32'd954437176,  32'd858993459,  32'd780903144,
    32'd715827882,  32'd660764199,  32'd613566756,  32'd572662306,
    32'd0
  };

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_POSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TAIL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TAIL    = 3'd4;

  typedef struct packed {
    logic           zero;
    logic           sat;
    logic [Q_W-1:0] q;
  } div_res_t;

  typedef struct packed {
    logic [OUT_BITS:0] density;
    logic              invalid;
  } exp_res_t;

endpackage
`default_nettype wire

FILE: rtl/cfe_div.sv
// pipelined restoring divider, one quotient bit per stage, with range check
`default_nettype none
module cfe_div
  import cfe_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  wire              in_valid,
  input  wire  [NUM_W-1:0] num,
  input  wire  [DEN_W-1:0] den,
  output logic             out_valid,
  output div_res_t         res
);

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } dstg_t;

  dstg_t      st_r   [Q_W+1];
  dstg_t      st_nxt [Q_W+1];
  logic [Q_W:0] v_r;

  // quotient of 2**Q_W or more is out of range
  always_comb begin
    st_nxt[0].zero = (den == '0);
    st_nxt[0].sat  = CMP_W'(num) >= (CMP_W'(den) << Q_W);
    st_nxt[0].rem  = num;
    st_nxt[0].den  = den;
    st_nxt[0].q    = '0;
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_bit
    localparam int B = Q_W - j;
    logic [CMP_W-1:0] trial;
    logic             ge;
    always_comb begin
      st_nxt[j] = st_r[j-1];
      trial = CMP_W'(st_r[j-1].den) << B;
      ge = CMP_W'(st_r[j-1].rem) >= trial;
      if (ge) begin
        st_nxt[j].rem = NUM_W'(CMP_W'(st_r[j-1].rem) - trial);
      end
      st_nxt[j].q[B] = ge;
    end
  end

  for (genvar s = 0; s <= Q_W; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-1:0], in_valid};
    end
  end

  assign out_valid = v_r[Q_W];
  assign res.zero  = st_r[Q_W].zero;
  assign res.sat   = st_r[Q_W].sat;
  assign res.q     = st_r[Q_W].q;

endmodule
`default_nettype wire

FILE: rtl/cfe_exp.sv
// pipelined exp(-q): series on the fraction, then one exp(-1) step per stage
`default_nettype none
module cfe_exp
  import cfe_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       en,
  input  wire       in_valid,
  input  div_res_t  in_res,
  output logic      out_valid,
  output exp_res_t  out_res
);

  localparam int TS_N  = 3 * NTERMS + 1;
  localparam int LAT   = TS_N + NPOW + 2;
  localparam int PRD_W = ACC_W + FX_W;
  localparam logic [PRD_W-1:0] RND_HALF = PRD_W'(1) << (FX_W - 1);
  localparam logic [ACC_W-1:0] OUT_RND  = ACC_W'(1) << (FX_W - 1 - OUT_BITS);

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [N_W-1:0]   n;
    logic [FX_W-1:0]  f;
    logic [ACC_W-1:0] term;
    logic [ACC_W-1:0] p;
    logic [ACC_W-1:0] acc;
  } tstg_t;

  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [N_W-1:0]   n;
    logic [ACC_W-1:0] acc;
  } pstg_t;

  tstg_t ts_r   [TS_N];
  tstg_t ts_nxt [TS_N];
  pstg_t pw_r   [NPOW+1];
  pstg_t pw_nxt [NPOW+1];
  exp_res_t fo_r, fo_nxt;
  logic [LAT-1:0] v_r;
  logic [ACC_W-1:0] dsum;

  always_comb begin
    ts_nxt[0].zero = in_res.zero;
    ts_nxt[0].sat  = in_res.sat;
    ts_nxt[0].n    = in_res.q[Q_W-1:FRAC_BITS];
    ts_nxt[0].f    = {in_res.q[FRAC_BITS-1:0], (FX_W - FRAC_BITS)'(0)};
    ts_nxt[0].term = FX_ONE;
    ts_nxt[0].p    = '0;
    ts_nxt[0].acc  = FX_ONE;
  end

  // term k: multiply by f, floor(p / k) by reciprocal or shift, correct by one
  for (genvar k = 1; k <= NTERMS; k++) begin : g_term
    localparam int SA = 3 * k - 2;
    logic [PRD_W-1:0]       prd_a;
    logic [ACC_W+RCP_W-1:0] prd_b;
    logic [ACC_W-1:0]       rem_c;
    logic [ACC_W-1:0]       term_c;

    always_comb begin
      ts_nxt[SA] = ts_r[SA-1];
      prd_a = ts_r[SA-1].term * ts_r[SA-1].f;
      ts_nxt[SA].p = prd_a[FX_W +: ACC_W];
    end

    always_comb begin
      ts_nxt[SA+1] = ts_r[SA];
      prd_b = ts_r[SA].p * RCP_TAB[k];
      if ((k & (k - 1)) == 0) begin
        ts_nxt[SA+1].term = ts_r[SA].p >> $clog2(k);
      end else begin
        ts_nxt[SA+1].term = ACC_W'(prd_b >> RCP_SHIFT);
      end
    end

    always_comb begin
      ts_nxt[SA+2] = ts_r[SA+1];
      rem_c  = ts_r[SA+1].p - ACC_W'(ts_r[SA+1].term * ACC_W'(k));
      term_c = ts_r[SA+1].term + ACC_W'(rem_c >= ACC_W'(k));
      ts_nxt[SA+2].term = term_c;
      if (k % 2 == 1) begin
        ts_nxt[SA+2].acc = ts_r[SA+1].acc - term_c;
      end else begin
        ts_nxt[SA+2].acc = ts_r[SA+1].acc + term_c;
      end
    end
  end

  always_comb begin
    pw_nxt[0].zero = ts_r[TS_N-1].zero;
    pw_nxt[0].sat  = ts_r[TS_N-1].sat;
    pw_nxt[0].n    = ts_r[TS_N-1].n;
    pw_nxt[0].acc  = ts_r[TS_N-1].acc;
  end

  // stage i applies the i-th exp(-1) factor when the integer part allows
  for (genvar i = 1; i <= NPOW; i++) begin : g_pow
    logic [PRD_W-1:0] pp;
    always_comb begin
      pw_nxt[i] = pw_r[i-1];
      pp = pw_r[i-1].acc * E1 + RND_HALF;
      if (N_W'(i - 1) < pw_r[i-1].n) begin
        pw_nxt[i].acc = pp[FX_W +: ACC_W];
      end
    end
  end

  always_comb begin
    dsum = pw_r[NPOW].acc + OUT_RND;
    fo_nxt.invalid = pw_r[NPOW].zero;
    if (pw_r[NPOW].zero || pw_r[NPOW].sat) begin
      fo_nxt.density = '0;
    end else begin
      fo_nxt.density = dsum[FX_W-OUT_BITS +: OUT_BITS+1];
    end
  end

  for (genvar s = 0; s < TS_N; s++) begin : g_treg
    always_ff @(posedge clk) begin
      if (en) begin
        ts_r[s] <= ts_nxt[s];
      end
    end
  end

  for (genvar s = 0; s <= NPOW; s++) begin : g_preg
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[s] <= pw_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo_r <= fo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_res   = fo_r;

endmodule
`default_nettype wire

FILE: rtl/cruijff_function_eval_core.sv
// top level of the cruijff function evaluator: config, front end, output skid
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_sample_value
// out      output     out_valid/out_ready  out_density, out_invalid
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while the output skid is empty (en high)
// an item passes 5 front-end stages, 22 divider stages, 49 series stages,
// the exp(-1) stages, the exp output register and the output register
// all stages share one enable; a two-entry output (register plus skid) takes
// one more item while out_ready is low, then in_ready drops until it drains
// reset (rst_n low, synchronous) clears valid bits and loads register defaults
`default_nettype none
`include "cruijff_function_eval_core_macros.svh"
module cruijff_function_eval_core
  import cfe_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  signed [WORD_W-1:0]   in_sample_value,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic        [OUT_BITS:0]   out_density,
  output logic                       out_invalid,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire         [CFG_IDX_W-1:0] cfg_index,
  input  wire         [WORD_W-1:0]   cfg_data
);

  typedef struct packed {
    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] t;
  } s1_t;

  typedef struct packed {
    logic [D2_W-1:0]   d2;
    logic [D2_W-1:0]   w2;
    logic [WORD_W-1:0] t;
  } s2_t;

  typedef struct packed {
    logic [D2_W-1:0] plo;
    logic [D2_W-1:0] phi;
    logic [D2_W-1:0] d2;
    logic [D2_W-1:0] w2;
  } s3_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [D2_W-1:0]   d2;
    logic [D2_W-1:0]   w2;
  } s4_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } s5_t;

  logic [WORD_W-1:0] peak_r, lw_r, rw_r, lt_r, rt_r;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  logic [5:1] v_r;
  logic en;
  logic [WORD_W-1:0] xb, mb;
  logic below;
  logic div_v;
  div_res_t div_res;
  logic pipe_v;
  exp_res_t exp_res;
  logic ov_r, sk_v_r;
  exp_res_t od_r, sk_d_r;
  logic take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      lw_r   <= WIDTH_RESET;
      rw_r   <= WIDTH_RESET;
      lt_r   <= '0;
      rt_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PEAK_POSITION: peak_r <= cfg_data;
        CFG_LEFT_WIDTH:    lw_r   <= cfg_data;
        CFG_RIGHT_WIDTH:   rw_r   <= cfg_data;
        CFG_LEFT_TAIL:     lt_r   <= cfg_data;
        CFG_RIGHT_TAIL:    rt_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !sk_v_r;
  assign in_ready = en;

  // offset binary turns the signed compare into an unsigned one
  always_comb begin
    xb = $unsigned(in_sample_value) ^ SIGN_BIT;
    mb = peak_r ^ SIGN_BIT;
    below = xb < mb;
    s1_nxt.mag = below ? mb - xb : xb - mb;
    s1_nxt.w   = below ? lw_r : rw_r;
    s1_nxt.t   = below ? lt_r : rt_r;
  end

  always_comb begin
    s2_nxt.d2 = s1_r.mag * s1_r.mag;
    s2_nxt.w2 = s1_r.w * s1_r.w;
    s2_nxt.t  = s1_r.t;
  end

  always_comb begin
    s3_nxt.plo = s2_r.t * s2_r.d2[WORD_W-1:0];
    s3_nxt.phi = s2_r.t * s2_r.d2[D2_W-1:WORD_W];
    s3_nxt.d2  = s2_r.d2;
    s3_nxt.w2  = s2_r.w2;
  end

  always_comb begin
    s4_nxt.prod = (PROD_W'(s3_r.phi) << WORD_W) + PROD_W'(s3_r.plo);
    s4_nxt.d2   = s3_r.d2;
    s4_nxt.w2   = s3_r.w2;
  end

  always_comb begin
    s5_nxt.den = DEN_W'({s4_r.w2, 1'b0}) + DEN_W'(s4_r.prod >> FRAC_BITS);
    s5_nxt.num = {s4_r.d2, FRAC_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:1], in_valid};
    end
  end

  cfe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[5]),
    .num       (s5_r.num),
    .den       (s5_r.den),
    .out_valid (div_v),
    .res       (div_res)
  );

  cfe_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_v),
    .in_res    (div_res),
    .out_valid (pipe_v),
    .out_res   (exp_res)
  );

  // the last pipeline item leaves whenever en is high
  assign take = out_ready || !ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (take) begin
      if (sk_v_r) begin
        ov_r   <= 1'b1;
        sk_v_r <= 1'b0;
      end else begin
        ov_r <= pipe_v;
      end
    end else if (pipe_v && en) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      od_r <= sk_v_r ? sk_d_r : exp_res;
    end else if (en) begin
      sk_d_r <= exp_res;
    end
  end

  assign out_valid   = ov_r;
  assign out_density = od_r.density;
  assign out_invalid = od_r.invalid;

  `CFE_ASSERT_NOW(a_skid_behind_out, sk_v_r, ov_r, "skid item without output item")
  `CFE_ASSERT_NOW(a_invalid_zero, ov_r && out_invalid, out_density == '0, "invalid item not zero")
  `CFE_ASSERT_NOW(a_density_range, ov_r, out_density <= DENSITY_ONE, "density above one")
  `CFE_ASSERT_NEXT(a_skid_holds, sk_v_r && !out_ready, sk_v_r && $stable(sk_d_r), "skid lost")

endmodule
`default_nettype wire
